>>> hdl/ihc_pkg.sv
// shared types and constants for the ipv4 l4 header classifier
package ihc_pkg;

  localparam int OFF_W = 16;
  localparam int MAX_FRAME_BYTES_DEF = 65535;

  typedef logic [OFF_W-1:0] off_t;

  localparam off_t ETH_HDR_BYTES   = 16'd14;
  localparam off_t ETHTYPE_HI_OFF  = 16'd12;
  localparam off_t ETHTYPE_LO_OFF  = 16'd13;
  localparam off_t IHL_OFF         = 16'd14;
  localparam off_t PROTO_OFF       = 16'd23;
  localparam off_t IPV4_MIN_END    = 16'd34;
  localparam off_t UDP_LEN_HI_REL  = 16'd4;
  localparam off_t UDP_LEN_LO_REL  = 16'd5;
  localparam off_t TCP_DOFF_REL    = 16'd12;
  localparam off_t ICMP_HDR_BYTES  = 16'd8;
  localparam off_t UDP_HDR_BYTES   = 16'd8;
  localparam off_t TCP_MIN_BYTES   = 16'd20;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IHL_MIN        = 4'd5;
  localparam logic [15:0] UDP_LEN_MIN    = 16'd8;

  typedef enum logic [7:0] {
    PROTO_ICMP = 8'd1,
    PROTO_TCP  = 8'd6,
    PROTO_UDP  = 8'd17
  } proto_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_UNSUP = 2'd2
  } status_t;

  typedef struct packed {
    off_t        len;
    logic [15:0] ether_type;
    logic [3:0]  header_words;
    logic [7:0]  proto_seen;
    logic [7:0]  type_seen;
    logic [3:0]  data_offset_words;
    logic [15:0] udp_length_field;
  } hdr_snap_t;

endpackage

>>> hdl/ipv4_l4_header_classifier_unit.sv
// top level of the ethernet / ipv4 / l4 header classifier
// Takes one frame byte per cycle while in_tready is high, with in_tlast on the final
// byte; each final byte yields one result item, which passes through the input
// register, the end-of-frame snapshot and the result register. in_tready
// drops only while a final byte waits behind a snapshot that the result side
// has not yet taken, which happens when out_tready is held low.
// Bytes that are not last produce nothing. out_tuser carries the status
// (ok, bad or short header, unsupported) and the other result fields sit in
// out_tdata; they are zero unless the status is ok. Frame length counting
// saturates at MAX_FRAME_BYTES, after which further bytes are not inspected.
module ipv4_l4_header_classifier_unit #(
  parameter int MAX_FRAME_BYTES = ihc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] l4_protocol, [13:8] ip_header_len,
                                  // [21:14] icmp_type, [27:22] tcp_header_len,
                                  // [43:28] udp_payload_len, [47:44] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic               snap_valid;
  logic               snap_ready;
  ihc_pkg::hdr_snap_t snap;
  logic [7:0]         l4_protocol;
  logic [5:0]         ip_header_len;
  logic [7:0]         icmp_type;
  logic [5:0]         tcp_header_len;
  logic [15:0]        udp_payload_len;

  ihc_capture #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  ihc_classify u_classify (
    .clk                 (clk),
    .rst_n               (rst_n),
    .snap_valid          (snap_valid),
    .snap_ready          (snap_ready),
    .snap                (snap),
    .out_valid           (out_tvalid),
    .out_ready           (out_tready),
    .out_status          (out_tuser),
    .out_l4_protocol     (l4_protocol),
    .out_ip_header_len   (ip_header_len),
    .out_icmp_type       (icmp_type),
    .out_tcp_header_len  (tcp_header_len),
    .out_udp_payload_len (udp_payload_len)
  );

  assign out_tdata = {4'b0000, udp_payload_len, tcp_header_len, icmp_type,
                      ip_header_len, l4_protocol};

endmodule

>>> hdl/ihc_capture.sv
// input register, per-frame header capture and end-of-frame snapshot
module ihc_capture #(
  parameter int MAX_FRAME_BYTES = ihc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              snap_valid,
  input  logic              snap_ready,
  output ihc_pkg::hdr_snap_t snap
);

  localparam ihc_pkg::off_t MAX_OFF = ihc_pkg::OFF_W'(MAX_FRAME_BYTES);

  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          s1_last_r;
  logic          s1_go;
  logic          s2_valid_r;
  logic          s2_free;

  ihc_pkg::off_t off_r, off_nxt;
  logic [15:0]   ether_r, ether_nxt;
  logic [3:0]    ihl_r, ihl_nxt;
  logic [7:0]    proto_r, proto_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [3:0]    doff_r, doff_nxt;
  logic [15:0]   udpl_r, udpl_nxt;
  ihc_pkg::off_t len;
  ihc_pkg::off_t l4_off;

  ihc_pkg::hdr_snap_t snap_r;

  assign s2_free   = !s2_valid_r || snap_ready;
  assign s1_go     = s1_valid_r && (!s1_last_r || s2_free);
  assign in_tready = !s1_valid_r || s1_go;

  assign l4_off = ihc_pkg::ETH_HDR_BYTES + ihc_pkg::OFF_W'({ihl_r, 2'b00});

  always_comb begin
    off_nxt   = off_r;
    ether_nxt = ether_r;
    ihl_nxt   = ihl_r;
    proto_nxt = proto_r;
    type_nxt  = type_r;
    doff_nxt  = doff_r;
    udpl_nxt  = udpl_r;
    len       = MAX_OFF;
    if (off_r < MAX_OFF) begin
      if (off_r == ihc_pkg::ETHTYPE_HI_OFF) ether_nxt[15:8] = s1_byte_r;
      if (off_r == ihc_pkg::ETHTYPE_LO_OFF) ether_nxt[7:0]  = s1_byte_r;
      if (off_r == ihc_pkg::IHL_OFF)        ihl_nxt         = s1_byte_r[3:0];
      if (off_r == ihc_pkg::PROTO_OFF)      proto_nxt       = s1_byte_r;
      if (off_r > ihc_pkg::IHL_OFF) begin
        if (off_r == l4_off)                             type_nxt        = s1_byte_r;
        if (off_r == l4_off + ihc_pkg::UDP_LEN_HI_REL)   udpl_nxt[15:8]  = s1_byte_r;
        if (off_r == l4_off + ihc_pkg::UDP_LEN_LO_REL)   udpl_nxt[7:0]   = s1_byte_r;
        if (off_r == l4_off + ihc_pkg::TCP_DOFF_REL)     doff_nxt        = s1_byte_r[7:4];
      end
      len     = off_r + ihc_pkg::OFF_W'(1);
      off_nxt = len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      ether_r <= '0;
      ihl_r   <= '0;
      proto_r <= '0;
      type_r  <= '0;
      doff_r  <= '0;
      udpl_r  <= '0;
    end else if (s1_go) begin
      if (s1_last_r) begin
        off_r   <= '0;
        ether_r <= '0;
        ihl_r   <= '0;
        proto_r <= '0;
        type_r  <= '0;
        doff_r  <= '0;
        udpl_r  <= '0;
      end else begin
        off_r   <= off_nxt;
        ether_r <= ether_nxt;
        ihl_r   <= ihl_nxt;
        proto_r <= proto_nxt;
        type_r  <= type_nxt;
        doff_r  <= doff_nxt;
        udpl_r  <= udpl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_go && s1_last_r;
    end
    if (s2_free && s1_go && s1_last_r) begin
      snap_r.len               <= len;
      snap_r.ether_type        <= ether_nxt;
      snap_r.header_words      <= ihl_nxt;
      snap_r.proto_seen        <= proto_nxt;
      snap_r.type_seen         <= type_nxt;
      snap_r.data_offset_words <= doff_nxt;
      snap_r.udp_length_field  <= udpl_nxt;
    end
  end

  assign snap_valid = s2_valid_r;
  assign snap       = snap_r;

endmodule

>>> hdl/ihc_classify.sv
// header length checks and classification into the result register
module ihc_classify (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               snap_valid,
  output logic               snap_ready,
  input  ihc_pkg::hdr_snap_t snap,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [7:0]         out_l4_protocol,
  output logic [5:0]         out_ip_header_len,
  output logic [7:0]         out_icmp_type,
  output logic [5:0]         out_tcp_header_len,
  output logic [15:0]        out_udp_payload_len
);

  logic              out_valid_r;
  ihc_pkg::status_t  status_r, status_nxt;
  logic [7:0]        proto_r, proto_nxt;
  logic [5:0]        iplen_r, iplen_nxt;
  logic [7:0]        icmp_r, icmp_nxt;
  logic [5:0]        tcplen_r, tcplen_nxt;
  logic [15:0]       udppl_r, udppl_nxt;
  ihc_pkg::off_t     l4_off;
  ihc_pkg::off_t     tcp_end;

  assign snap_ready = !out_valid_r || out_ready;

  assign l4_off  = ihc_pkg::ETH_HDR_BYTES + ihc_pkg::OFF_W'({snap.header_words, 2'b00});
  assign tcp_end = l4_off + ihc_pkg::OFF_W'({snap.data_offset_words, 2'b00});

  always_comb begin
    status_nxt = ihc_pkg::ST_BAD;
    proto_nxt  = '0;
    iplen_nxt  = '0;
    icmp_nxt   = '0;
    tcplen_nxt = '0;
    udppl_nxt  = '0;
    priority if (snap.len < ihc_pkg::ETH_HDR_BYTES) begin
      status_nxt = ihc_pkg::ST_BAD;
    end else if (snap.ether_type != ihc_pkg::ETHERTYPE_IPV4) begin
      status_nxt = ihc_pkg::ST_UNSUP;
    end else if (snap.len < ihc_pkg::IPV4_MIN_END || snap.header_words < ihc_pkg::IHL_MIN ||
                 snap.len < l4_off) begin
      status_nxt = ihc_pkg::ST_BAD;
    end else if (snap.proto_seen == ihc_pkg::PROTO_ICMP) begin
      if (snap.len >= l4_off + ihc_pkg::ICMP_HDR_BYTES) begin
        status_nxt = ihc_pkg::ST_OK;
        icmp_nxt   = snap.type_seen;
      end
    end else if (snap.proto_seen == ihc_pkg::PROTO_TCP) begin
      if (snap.len >= l4_off + ihc_pkg::TCP_MIN_BYTES && snap.len >= tcp_end) begin
        status_nxt = ihc_pkg::ST_OK;
        tcplen_nxt = {snap.data_offset_words, 2'b00};
      end
    end else if (snap.proto_seen == ihc_pkg::PROTO_UDP) begin
      if (snap.len >= l4_off + ihc_pkg::UDP_HDR_BYTES &&
          snap.udp_length_field >= ihc_pkg::UDP_LEN_MIN) begin
        status_nxt = ihc_pkg::ST_OK;
        udppl_nxt  = snap.udp_length_field - ihc_pkg::UDP_LEN_MIN;
      end
    end else begin
      status_nxt = ihc_pkg::ST_UNSUP;
    end
    if (status_nxt == ihc_pkg::ST_OK) begin
      proto_nxt = snap.proto_seen;
      iplen_nxt = {snap.header_words, 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_ready) begin
      out_valid_r <= snap_valid;
    end
    if (snap_ready && snap_valid) begin
      status_r <= status_nxt;
      proto_r  <= proto_nxt;
      iplen_r  <= iplen_nxt;
      icmp_r   <= icmp_nxt;
      tcplen_r <= tcplen_nxt;
      udppl_r  <= udppl_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_l4_protocol     = proto_r;
  assign out_ip_header_len   = iplen_r;
  assign out_icmp_type       = icmp_r;
  assign out_tcp_header_len  = tcplen_r;
  assign out_udp_payload_len = udppl_r;

endmodule

>>> hdl/ihc_checker.sv
// port-level checks for the header classifier, bound to the top level
module ihc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);

  logic ok;
  assign ok = out_tuser == ihc_pkg::ST_OK;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ihc_pkg::ST_OK || out_tuser == ihc_pkg::ST_BAD ||
                    out_tuser == ihc_pkg::ST_UNSUP))
    else $error("status out of range");

  // fields are zero unless the header chain was good
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !ok |-> out_tdata == 48'd0)
    else $error("fields set on a failed frame");

  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ok |-> out_tdata[13:8] >= 6'd20 && out_tdata[47:44] == 4'd0 &&
      ((out_tdata[7:0] == ihc_pkg::PROTO_ICMP && out_tdata[43:22] == 22'd0) ||
       (out_tdata[7:0] == ihc_pkg::PROTO_TCP && out_tdata[43:28] == 16'd0 &&
        out_tdata[21:14] == 8'd0) ||
       (out_tdata[7:0] == ihc_pkg::PROTO_UDP && out_tdata[27:14] == 14'd0)))
    else $error("inconsistent fields on a good frame");

  // in_tready drops only after a byte was offered or while it was already low
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !in_tready |-> $past(in_tvalid) || $past(!in_tready))
    else $error("input stalled without cause");

endmodule

bind ipv4_l4_header_classifier_unit ihc_checker u_ihc_checker (.*);

>>> bench/tb.sv
// self-checking testbench for the ipv4 l4 header classifier unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_CAP = 65535;
  localparam int HOLD_CYCLES = 300;
  localparam int LATENCY = 2;
  localparam int ITEM_TARGET = 760;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  logic [7:0]  frame_bytes[$];
  bit          hold_req;
  int          bytes_sent;

  ipv4_l4_header_classifier_unit #(
    .MAX_FRAME_BYTES(FRAME_CAP)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  typedef struct packed {
    ihc_pkg::status_t st;
    logic [7:0]       proto;
    logic [5:0]       ip_len;
    logic [7:0]       icmp;
    logic [5:0]       tcp_len;
    logic [15:0]      udp_len;
  } verdict_t;

  class header_verdict_board;
    ihc_pkg::off_t frame_pos;
    logic [15:0]   ether_type;
    logic [3:0]    header_words;
    logic [7:0]    proto_seen;
    logic [7:0]    type_seen;
    logic [3:0]    data_offset_words;
    logic [15:0]   udp_length_field;
    verdict_t      pending[$];
    int            errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      frame_pos = '0;
      ether_type = '0;
      header_words = '0;
      proto_seen = '0;
      type_seen = '0;
      data_offset_words = '0;
      udp_length_field = '0;
    endfunction

    function void capture(int unsigned off, logic [7:0] b);
      int unsigned l4;
      l4 = ihc_pkg::ETH_HDR_BYTES + 4 * header_words;
      if (off == ihc_pkg::ETHTYPE_HI_OFF) ether_type[15:8] = b;
      if (off == ihc_pkg::ETHTYPE_LO_OFF) ether_type[7:0] = b;
      if (off == ihc_pkg::IHL_OFF) header_words = b[3:0];
      if (off == ihc_pkg::PROTO_OFF) proto_seen = b;
      if (off > ihc_pkg::IHL_OFF) begin
        if (off == l4) type_seen = b;
        if (off == l4 + ihc_pkg::UDP_LEN_HI_REL) udp_length_field[15:8] = b;
        if (off == l4 + ihc_pkg::UDP_LEN_LO_REL) udp_length_field[7:0] = b;
        if (off == l4 + ihc_pkg::TCP_DOFF_REL) data_offset_words = b[7:4];
      end
    endfunction

    function verdict_t classify(int unsigned len);
      verdict_t    v;
      int unsigned ip_bytes;
      int unsigned l4;
      v = '0;
      v.st = ihc_pkg::ST_BAD;
      if (len < ihc_pkg::ETH_HDR_BYTES) return v;
      if (ether_type != ihc_pkg::ETHERTYPE_IPV4) begin
        v.st = ihc_pkg::ST_UNSUP;
        return v;
      end
      if (len < ihc_pkg::IPV4_MIN_END) return v;
      if (header_words < ihc_pkg::IHL_MIN) return v;
      ip_bytes = 4 * header_words;
      l4 = ihc_pkg::ETH_HDR_BYTES + ip_bytes;
      if (len < l4) return v;
      case (proto_seen)
        ihc_pkg::PROTO_ICMP: begin
          if (len < l4 + ihc_pkg::ICMP_HDR_BYTES) return v;
          v.icmp = type_seen;
        end
        ihc_pkg::PROTO_TCP: begin
          if (len < l4 + ihc_pkg::TCP_MIN_BYTES) return v;
          if (len < l4 + 4 * data_offset_words) return v;
          v.tcp_len = 6'(4 * data_offset_words);
        end
        ihc_pkg::PROTO_UDP: begin
          if (len < l4 + ihc_pkg::UDP_HDR_BYTES) return v;
          if (udp_length_field < ihc_pkg::UDP_LEN_MIN) return v;
          v.udp_len = udp_length_field - ihc_pkg::UDP_HDR_BYTES;
        end
        default: begin
          v.st = ihc_pkg::ST_UNSUP;
          return v;
        end
      endcase
      v.st = ihc_pkg::ST_OK;
      v.proto = proto_seen;
      v.ip_len = 6'(ip_bytes);
      return v;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      if (frame_pos < FRAME_CAP) begin
        capture(frame_pos, b);
        frame_pos++;
      end
      if (last) begin
        pending.push_back(classify(frame_pos));
        clear();
      end
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_verdict(logic [47:0] d, logic [1:0] u);
      verdict_t v;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result item with none expected: expected nothing, got tdata %h tuser %h",
                 $time, d, u);
        return;
      end
      v = pending.pop_front();
      check_field("status", v.st, u);
      check_field("l4_protocol", v.proto, d[7:0]);
      check_field("ip_header_len", v.ip_len, d[13:8]);
      check_field("icmp_type", v.icmp, d[21:14]);
      check_field("tcp_header_len", v.tcp_len, d[27:22]);
      check_field("udp_payload_len", v.udp_len, d[43:28]);
      check_field("padding", '0, d[47:44]);
    endfunction
  endclass

  header_verdict_board board;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #1ms;
    $display("ipv4_l4_header_classifier_unit test failed");
    $finish;
  end

  function automatic int frame_need(logic [3:0] ihl, logic [7:0] proto, logic [3:0] doff);
    int l4;
    int need;
    l4 = 14 + 4 * ihl;
    need = (l4 < 34) ? 34 : l4;
    if (proto == ihc_pkg::PROTO_ICMP || proto == ihc_pkg::PROTO_UDP) begin
      if (l4 + 8 > need) need = l4 + 8;
    end else if (proto == ihc_pkg::PROTO_TCP) begin
      need = l4 + ((4 * doff > 20) ? 4 * doff : 20);
    end
    return need;
  endfunction

  function automatic void poke(int idx, logic [7:0] val);
    if (idx < frame_bytes.size()) frame_bytes[idx] = val;
  endfunction

  task automatic wait_drained();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // builds a frame with the given header fields over random bytes and drives it
  task automatic send_header_frame(logic [15:0] etype, logic [3:0] ihl, logic [7:0] proto,
                                   logic [3:0] doff, logic [15:0] ulen, logic [7:0] first,
                                   int len, bit steady);
    int l4;
    int gap;
    bit calm;
    frame_bytes.delete();
    for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
    l4 = 14 + 4 * ihl;
    poke(l4, first);
    poke(l4 + 4, ulen[15:8]);
    poke(l4 + 5, ulen[7:0]);
    poke(l4 + 12, {doff, 4'($urandom)});
    poke(12, etype[15:8]);
    poke(13, etype[7:0]);
    poke(14, {4'($urandom), ihl});
    poke(23, proto);
    calm = steady || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_tdata = frame_bytes[i];
      in_tlast = (i == len - 1);
      in_tvalid = 1'b1;
      do @(posedge clk); while (!in_tready);
      board.take_byte(in_tdata, in_tlast);
      @(negedge clk);
    end
    bytes_sent += len;
  endtask

  task automatic send_random_frame();
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  proto;
    logic [15:0] ulen;
    int          need;
    int          len;
    int          r;
    etype = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ihc_pkg::ETHERTYPE_IPV4;
    if ($urandom_range(0, 7) == 0) ihl = 4'($urandom_range(0, 4));
    else if ($urandom_range(0, 1) == 0) ihl = ihc_pkg::IHL_MIN;
    else ihl = 4'($urandom_range(5, 15));
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: proto = ihc_pkg::PROTO_ICMP;
      3, 4, 5: proto = ihc_pkg::PROTO_TCP;
      6, 7, 8: proto = ihc_pkg::PROTO_UDP;
      default: proto = 8'($urandom);
    endcase
    doff = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(5, 15));
    ulen = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    need = frame_need(ihl, proto, doff);
    r = $urandom_range(0, 9);
    if (r < 7) len = need + $urandom_range(0, 6);
    else if (r < 9) len = need - $urandom_range(1, 4);
    else len = $urandom_range(1, need);
    if (len < 1) len = 1;
    send_header_frame(etype, ihl, proto, doff, ulen, 8'($urandom), len, 1'b0);
  endtask

  // result side: random stalls, steady stretches, and one long hold-off on request
  initial begin
    int  stall;
    bit  rx_steady;
    out_tready = 1'b0;
    rx_steady = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 7) == 0) rx_steady = !rx_steady;
        stall = rx_steady ? 0 : $urandom_range(0, 5);
        if (stall > 0) begin
          out_tready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      board.check_verdict(out_tdata, out_tuser);
      @(negedge clk);
    end
  end

  initial begin
    board = new();
    hold_req = 1'b0;
    bytes_sent = 0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // runt frames and an ethertype that is not ipv4
    send_header_frame(ihc_pkg::ETHERTYPE_IPV4, ihc_pkg::IHL_MIN, ihc_pkg::PROTO_UDP, 4'd5,
                      16'd20, 8'h00, 1, 1'b0);
    send_header_frame(ihc_pkg::ETHERTYPE_IPV4, ihc_pkg::IHL_MIN, ihc_pkg::PROTO_UDP, 4'd5,
                      16'd20, 8'h00, 13, 1'b0);
    send_header_frame(16'h86DD, ihc_pkg::IHL_MIN, ihc_pkg::PROTO_UDP, 4'd5,
                      16'd20, 8'h00, 14, 1'b0);
    send_header_frame(ihc_pkg::ETHERTYPE_IPV4, ihc_pkg::IHL_MIN, ihc_pkg::PROTO_UDP, 4'd5,
                      16'd20, 8'h00, 33, 1'b0);
    // ihl below the minimum
    send_header_frame(ihc_pkg::ETHERTYPE_IPV4, 4'd4, ihc_pkg::PROTO_TCP, 4'd5,
                      16'd20, 8'h00, 34, 1'b0);
    // icmp exact length and one byte short
    send_header_frame(ihc_pkg::ETHERTYPE_IPV4, ihc_pkg::IHL_MIN, ihc_pkg::PROTO_ICMP, 4'd0,
                      16'd0, 8'hFF, 42, 1'b0);
    send_header_frame(ihc_pkg::ETHERTYPE_IPV4, ihc_pkg::IHL_MIN, ihc_pkg::PROTO_ICMP, 4'd0,
                      16'd0, 8'h08, 41, 1'b0);
    // tcp: largest headers and short doff
    send_header_frame(ihc_pkg::ETHERTYPE_IPV4, 4'd15, ihc_pkg::PROTO_TCP, 4'd15,
                      16'hFFFF, 8'h00, 134, 1'b0);
    send_header_frame(ihc_pkg::ETHERTYPE_IPV4, ihc_pkg::IHL_MIN, ihc_pkg::PROTO_TCP, 4'd3,
                      16'd0, 8'h00, 54, 1'b0);
    // udp length field below and at eight
    send_header_frame(ihc_pkg::ETHERTYPE_IPV4, ihc_pkg::IHL_MIN, ihc_pkg::PROTO_UDP, 4'd0,
                      16'd7, 8'h00, 42, 1'b0);
    send_header_frame(ihc_pkg::ETHERTYPE_IPV4, ihc_pkg::IHL_MIN, ihc_pkg::PROTO_UDP, 4'd0,
                      16'd8, 8'h00, 42, 1'b0);
    // protocols that are not handled
    send_header_frame(ihc_pkg::ETHERTYPE_IPV4, ihc_pkg::IHL_MIN, 8'd0, 4'd5,
                      16'd20, 8'h00, 34, 1'b0);
    send_header_frame(ihc_pkg::ETHERTYPE_IPV4, ihc_pkg::IHL_MIN, 8'hFF, 4'd5,
                      16'd20, 8'h00, 34, 1'b0);

    // back-to-back one-byte frames against a long receiver hold-off
    send_header_frame(ihc_pkg::ETHERTYPE_IPV4, ihc_pkg::IHL_MIN, ihc_pkg::PROTO_ICMP, 4'd0,
                      16'd0, 8'h03, 1, 1'b0);
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++)
      send_header_frame(ihc_pkg::ETHERTYPE_IPV4, ihc_pkg::IHL_MIN, ihc_pkg::PROTO_UDP, 4'd0,
                        16'd0, 8'h00, 1, 1'b1);
    in_tvalid = 1'b0;
    wait_drained();
    @(negedge clk);

    while (bytes_sent < ITEM_TARGET)
      send_random_frame();
    in_tvalid = 1'b0;
    in_tlast = 1'b0;

    wait_drained();
    repeat (LATENCY + 5) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("ipv4_l4_header_classifier_unit test passed");
    else
      $display("ipv4_l4_header_classifier_unit test failed");
    $finish;
  end

endmodule
